// ===== hw/rtl/dcc_pkg.sv =====
`timescale 1ns / 1ps

package dcc_pkg;

   localparam int DUR_W        = 15;
   localparam int PMIN_W       = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 15;
   localparam int MAX_BYTES_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int MIN_PACKET   = 3;

   localparam logic [DUR_W-1:0]  GLITCH_LIMIT_RST = 15'd15;
   localparam logic [DUR_W-1:0]  ONE_MIN_RST      = 15'd48;
   localparam logic [DUR_W-1:0]  ONE_MAX_RST      = 15'd72;
   localparam logic [DUR_W-1:0]  ZERO_MIN_RST     = 15'd85;
   localparam logic [DUR_W-1:0]  ZERO_MAX_RST     = 15'd12000;
   localparam logic [PMIN_W-1:0] PREAMBLE_MIN_RST = 8'd10;

   localparam logic [7:0] IDLE_FIRST  = 8'hFF;
   localparam logic [7:0] IDLE_SECOND = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLITCH_LIMIT = 3'd0,
      CSR_ONE_MIN      = 3'd1,
      CSR_ONE_MAX      = 3'd2,
      CSR_ZERO_MIN     = 3'd3,
      CSR_ZERO_MAX     = 3'd4,
      CSR_PREAMBLE_MIN = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DUR_W-1:0]  glitch_limit;
      logic [DUR_W-1:0]  one_min;
      logic [DUR_W-1:0]  one_max;
      logic [DUR_W-1:0]  zero_min;
      logic [DUR_W-1:0]  zero_max;
      logic [PMIN_W-1:0] preamble_min;
   } cfg_type;

   typedef enum logic [1:0] {
      CLS_INVALID = 2'd0,
      CLS_ONE     = 2'd1,
      CLS_ZERO    = 2'd2
   } cls_type;

   typedef enum logic [1:0] {
      PH_PREAMBLE = 2'd0,
      PH_BYTE     = 2'd1,
      PH_SEP      = 2'd2
   } phase_type;

   typedef enum logic {
      BK_PARSE = 1'b0,
      BK_EMIT  = 1'b1
   } back_state_type;

endpackage

// ===== hw/rtl/dcc_front.sv =====
`timescale 1ns / 1ps

module dcc_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dcc_pkg::DUR_W-1:0]   req_half_duration,
   input  dcc_pkg::cfg_type            cfg,
   input  logic                        q_full,
   output logic                        q_push,
   output dcc_pkg::cls_type            q_push_cls
);
   import dcc_pkg::*;

   logic in_one;
   logic in_zero;

   assign req_stall = q_full;

   // one range wins where the ranges overlap
   assign in_one  = (req_half_duration >= cfg.one_min) && (req_half_duration <= cfg.one_max);
   assign in_zero = (req_half_duration >= cfg.zero_min) && (req_half_duration <= cfg.zero_max);

   // glitches never reach the queue
   assign q_push = req_valid && !q_full && (req_half_duration >= cfg.glitch_limit);

   always_comb begin
      if (in_one) begin
         q_push_cls = CLS_ONE;
      end else if (in_zero) begin
         q_push_cls = CLS_ZERO;
      end else begin
         q_push_cls = CLS_INVALID;
      end
   end

endmodule

// ===== hw/rtl/dcc_queue.sv =====
`timescale 1ns / 1ps

module dcc_queue #(
   parameter int DEPTH = dcc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dcc_pkg::cls_type push_cls,
   output logic             full,
   output logic             q_valid,
   output dcc_pkg::cls_type q_cls,
   input  logic             pop
);
   import dcc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cls   = entry_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cls;
      end
   end

endmodule

// ===== hw/rtl/dcc_back.sv =====
`timescale 1ns / 1ps

module dcc_back #(
   parameter int MAX_BYTES = dcc_pkg::MAX_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dcc_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  dcc_pkg::cls_type    q_cls,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_data_byte,
   output logic [2:0]          rsp_byte_index,
   output logic [3:0]          rsp_packet_length,
   output logic                rsp_checksum_ok,
   output logic                rsp_is_idle,
   output logic                rsp_last
);
   import dcc_pkg::*;

   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam int IDX_W = $clog2(MAX_BYTES);

   back_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic              awaiting_ff, awaiting_in;
   logic              first_one_ff, first_one_in;
   logic [7:0]        preamble_ff, preamble_in;
   logic [7:0]        ones_run_ff, ones_run_in;
   logic [7:0]        shift_ff, shift_in;
   logic [3:0]        bits_ff, bits_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [7:0]        xor_ff, xor_in;
   logic              first_ff_byte_ff, first_ff_byte_in;
   logic              second_zero_ff, second_zero_in;
   logic [IDX_W-1:0]  emit_idx_ff, emit_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [7:0]        rsp_data_byte_ff;
   logic [2:0]        rsp_byte_index_ff;
   logic [3:0]        rsp_packet_length_ff;
   logic              rsp_checksum_ok_ff;
   logic              rsp_is_idle_ff;
   logic              rsp_last_ff;

   logic [7:0]        store_mem [MAX_BYTES];
   logic              mem_we;
   logic [7:0]        mem_wdata;
   logic              rd_load;
   logic [IDX_W-1:0]  last_idx;

   logic              is_one;
   logic              is_zero;
   logic              take;
   logic              bit_val;
   logic [7:0]        ones_new;
   logic [7:0]        shift_new;
   logic [3:0]        bits_new;

   assign last_idx = IDX_W'(stored_ff - CNT_W'(1));

   always_comb begin
      state_in          = state_ff;
      phase_in          = phase_ff;
      awaiting_in       = awaiting_ff;
      first_one_in      = first_one_ff;
      preamble_in       = preamble_ff;
      ones_run_in       = ones_run_ff;
      shift_in          = shift_ff;
      bits_in           = bits_ff;
      stored_in         = stored_ff;
      xor_in            = xor_ff;
      first_ff_byte_in  = first_ff_byte_ff;
      second_zero_in    = second_zero_ff;
      emit_idx_in       = emit_idx_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      q_pop             = 1'b0;
      mem_we            = 1'b0;
      rd_load           = 1'b0;
      is_one            = (q_cls == CLS_ONE);
      is_zero           = (q_cls == CLS_ZERO);
      take              = 1'b0;
      bit_val           = first_one_ff;
      ones_new          = '0;
      shift_new         = {shift_ff[6:0], first_one_ff};
      bits_new          = bits_ff + 4'd1;
      mem_wdata         = shift_new;

      unique case (state_ff)
         BK_PARSE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!is_one && !is_zero) begin
                  awaiting_in = 1'b0;
               end else if (!awaiting_ff) begin
                  first_one_in = is_one;
                  awaiting_in  = 1'b1;
               end else if ((is_one == first_one_ff) ||
                            (first_one_ff && is_zero && phase_ff == PH_SEP &&
                             stored_ff >= CNT_W'(MIN_PACKET))) begin
                  // stretched last half of the separator still counts as a one
                  awaiting_in = 1'b0;
                  take        = 1'b1;
               end else begin
                  first_one_in = is_one;
               end
            end

            if (take) begin
               if (bit_val) begin
                  ones_new = (ones_run_ff == 8'hFF) ? ones_run_ff : ones_run_ff + 8'd1;
               end
               ones_run_in = ones_new;
               if (bit_val && ones_new >= cfg.preamble_min && phase_ff != PH_PREAMBLE) begin
                  // long run of ones: resync to the preamble
                  phase_in    = PH_PREAMBLE;
                  preamble_in = ones_new;
               end else begin
                  case (phase_ff)
                     PH_PREAMBLE: begin
                        if (bit_val) begin
                           preamble_in = (preamble_ff == 8'hFF) ? preamble_ff
                                                                : preamble_ff + 8'd1;
                        end else if (preamble_ff >= cfg.preamble_min) begin
                           phase_in         = PH_BYTE;
                           shift_in         = '0;
                           bits_in          = '0;
                           stored_in        = '0;
                           xor_in           = '0;
                           first_ff_byte_in = 1'b0;
                           second_zero_in   = 1'b0;
                        end else begin
                           preamble_in = '0;
                        end
                     end
                     PH_BYTE: begin
                        shift_in = shift_new;
                        bits_in  = bits_new;
                        if (bits_new == 4'd8) begin
                           if (stored_ff < CNT_W'(MAX_BYTES)) begin
                              mem_we    = 1'b1;
                              stored_in = stored_ff + CNT_W'(1);
                              xor_in    = xor_ff ^ shift_new;
                              if (stored_ff == CNT_W'(0)) begin
                                 first_ff_byte_in = (shift_new == IDLE_FIRST);
                              end
                              if (stored_ff == CNT_W'(1)) begin
                                 second_zero_in = (shift_new == IDLE_SECOND);
                              end
                           end
                           phase_in = PH_SEP;
                        end
                     end
                     PH_SEP: begin
                        if (!bit_val) begin
                           phase_in = PH_BYTE;
                           shift_in = '0;
                           bits_in  = '0;
                        end else begin
                           if (stored_ff >= CNT_W'(MIN_PACKET)) begin
                              state_in    = BK_EMIT;
                              emit_idx_in = '0;
                           end
                           phase_in    = PH_PREAMBLE;
                           preamble_in = '0;
                        end
                     end
                     default: begin
                        phase_in = PH_PREAMBLE;
                     end
                  endcase
               end
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rd_load      = 1'b1;
               rsp_valid_in = 1'b1;
               emit_idx_in  = emit_idx_ff + IDX_W'(1);
               if (emit_idx_ff == last_idx) begin
                  state_in = BK_PARSE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BK_PARSE;
         phase_ff         <= PH_PREAMBLE;
         awaiting_ff      <= 1'b0;
         first_one_ff     <= 1'b0;
         preamble_ff      <= '0;
         ones_run_ff      <= '0;
         shift_ff         <= '0;
         bits_ff          <= '0;
         stored_ff        <= '0;
         xor_ff           <= '0;
         first_ff_byte_ff <= 1'b0;
         second_zero_ff   <= 1'b0;
         emit_idx_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         awaiting_ff      <= awaiting_in;
         first_one_ff     <= first_one_in;
         preamble_ff      <= preamble_in;
         ones_run_ff      <= ones_run_in;
         shift_ff         <= shift_in;
         bits_ff          <= bits_in;
         stored_ff        <= stored_in;
         xor_ff           <= xor_in;
         first_ff_byte_ff <= first_ff_byte_in;
         second_zero_ff   <= second_zero_in;
         emit_idx_ff      <= emit_idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[stored_ff[IDX_W-1:0]] <= mem_wdata;
      end
   end

   // output beat: packet-wide flags are frozen while the bytes drain
   always_ff @(posedge clock) begin
      if (rd_load) begin
         rsp_data_byte_ff     <= store_mem[emit_idx_ff];
         rsp_byte_index_ff    <= 3'(emit_idx_ff);
         rsp_packet_length_ff <= 4'(stored_ff);
         rsp_checksum_ok_ff   <= (xor_ff == 8'h00);
         rsp_is_idle_ff       <= first_ff_byte_ff && second_zero_ff;
         rsp_last_ff          <= (emit_idx_ff == last_idx);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_data_byte_ff;
   assign rsp_byte_index    = rsp_byte_index_ff;
   assign rsp_packet_length = rsp_packet_length_ff;
   assign rsp_checksum_ok   = rsp_checksum_ok_ff;
   assign rsp_is_idle       = rsp_is_idle_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== hw/rtl/dcc_bit_and_packet_receiver_top.sv =====
// the half-cycle ending a packet passes the queue, the emit state and the rsp register
// input: one half-cycle per clock while the queue is not full; a finished packet holds the
//   parser while its bytes (three to MAX_BYTES) drain through the output register
// the classified-half queue lets the front keep taking beats during that drain
// reset: synchronous; clears parser, queue and output valid, and reloads the csr defaults
`timescale 1ns / 1ps

module dcc_bit_and_packet_receiver_top #(
   parameter int MAX_BYTES   = dcc_pkg::MAX_BYTES_DEF,
   parameter int QUEUE_DEPTH = dcc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dcc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dcc_pkg::DUR_W-1:0]        req_half_duration,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_data_byte,
   output logic [2:0]                       rsp_byte_index,
   output logic [3:0]                       rsp_packet_length,
   output logic                             rsp_checksum_ok,
   output logic                             rsp_is_idle,
   output logic                             rsp_last
);
   import dcc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    q_push;
   cls_type q_push_cls;
   logic    q_valid;
   cls_type q_cls;
   logic    q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GLITCH_LIMIT: cfg_in.glitch_limit = csr_wdata[DUR_W-1:0];
            CSR_ONE_MIN:      cfg_in.one_min      = csr_wdata[DUR_W-1:0];
            CSR_ONE_MAX:      cfg_in.one_max      = csr_wdata[DUR_W-1:0];
            CSR_ZERO_MIN:     cfg_in.zero_min     = csr_wdata[DUR_W-1:0];
            CSR_ZERO_MAX:     cfg_in.zero_max     = csr_wdata[DUR_W-1:0];
            CSR_PREAMBLE_MIN: cfg_in.preamble_min = csr_wdata[PMIN_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glitch_limit <= GLITCH_LIMIT_RST;
         cfg_ff.one_min      <= ONE_MIN_RST;
         cfg_ff.one_max      <= ONE_MAX_RST;
         cfg_ff.zero_min     <= ZERO_MIN_RST;
         cfg_ff.zero_max     <= ZERO_MAX_RST;
         cfg_ff.preamble_min <= PREAMBLE_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcc_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_half_duration (req_half_duration),
      .cfg               (cfg_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_push_cls        (q_push_cls)
   );

   dcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cls (q_push_cls),
      .full     (q_full),
      .q_valid  (q_valid),
      .q_cls    (q_cls),
      .pop      (q_pop)
   );

   dcc_back #(
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_cls             (q_cls),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_packet_length (rsp_packet_length),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_is_idle       (rsp_is_idle),
      .rsp_last          (rsp_last)
   );

   // final byte sits at the end of the packet
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_byte_index == 3'(rsp_packet_length - 4'd1))
      else $error("last byte index does not match packet length");

   // bytes of a packet leave back to back in order
   a_next_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_byte_index == $past(rsp_byte_index) + 3'd1)
      else $error("packet byte missing or out of order");

   // packet-wide fields hold across the bytes of one packet
   a_packet_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         $stable(rsp_packet_length) && $stable(rsp_checksum_ok) && $stable(rsp_is_idle))
      else $error("packet flags changed within a packet");

endmodule

// ===== sim/tb_dcc_bit_and_packet_receiver_top.sv =====
`timescale 1ns / 1ps

module tb_dcc_bit_and_packet_receiver_top;
   import dcc_pkg::*;

   localparam int PKT_CAP = MAX_BYTES_DEF;
   localparam int DUR_MAX = (1 << DUR_W) - 1;
   localparam int RESET_CYCLES = 10;
   localparam int SETTLE = 32;
   localparam int LIMIT = 200000;
   localparam int HOLD_AT = 400;
   localparam int HOLD_LEN = 400;
   localparam int NUM_PHASES = 5;
   localparam logic [7:0] SAT = 8'hFF;

   typedef struct {
      logic [7:0] data;
      logic [2:0] index;
      logic [3:0] length;
      logic       good;
      logic       idle;
      logic       last;
   } rx_byte_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DUR_W-1:0]      req_half_duration = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_data_byte;
   logic [2:0]            rsp_byte_index;
   logic [3:0]            rsp_packet_length;
   logic                  rsp_checksum_ok;
   logic                  rsp_is_idle;
   logic                  rsp_last;

   // settings as the decoder currently holds them
   cfg_type cfg = '{GLITCH_LIMIT_RST, ONE_MIN_RST, ONE_MAX_RST,
                    ZERO_MIN_RST, ZERO_MAX_RST, PREAMBLE_MIN_RST};

   // decoder state as predicted
   bit         half_open = 1'b0;
   bit         open_is_one = 1'b0;
   phase_type  rx_phase = PH_PREAMBLE;
   logic [7:0] lead_ones = '0;
   logic [7:0] ones_streak = '0;
   logic [7:0] byte_sr = '0;
   logic [3:0] bit_count = '0;
   logic [3:0] byte_count = '0;
   logic [7:0] pkt_bytes [PKT_CAP];

   logic [DUR_W-1:0] half_queue [$];
   rx_byte_t         due_bytes [$];
   int               halves_made = 0;
   int               bytes_predicted = 0;
   int               beats_in = 0;
   int               cycles = 0;
   int               errors = 0;
   int               hold_left = 0;
   bit               hold_used = 1'b0;
   bit               no_gaps = 1'b0;
   logic             req_took = 1'b0;

   dcc_bit_and_packet_receiver_top u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_half_duration (req_half_duration),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_packet_length (rsp_packet_length),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_is_idle       (rsp_is_idle),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic queue_packet_bytes();
      logic [7:0] x;
      bit good, idle;
      rx_byte_t b;
      x = '0;
      for (int i = 0; i < byte_count - 1; i++) x ^= pkt_bytes[i];
      good = (x == pkt_bytes[byte_count - 1]);
      idle = (pkt_bytes[0] == IDLE_FIRST && pkt_bytes[1] == IDLE_SECOND);
      for (int i = 0; i < byte_count; i++) begin
         b.data = pkt_bytes[i];
         b.index = 3'(i);
         b.length = byte_count;
         b.good = good;
         b.idle = idle;
         b.last = (i == byte_count - 1);
         due_bytes.push_back(b);
         bytes_predicted++;
      end
   endtask

   task automatic decode_bit(input bit b);
      if (b) begin
         if (ones_streak != SAT) ones_streak = ones_streak + 1'b1;
         // a long enough run of ones drags the parser back to the preamble
         if (ones_streak >= cfg.preamble_min && rx_phase != PH_PREAMBLE) begin
            rx_phase = PH_PREAMBLE;
            lead_ones = ones_streak;
            return;
         end
      end else begin
         ones_streak = '0;
      end
      case (rx_phase)
         PH_PREAMBLE: begin
            if (b) begin
               if (lead_ones != SAT) lead_ones = lead_ones + 1'b1;
            end else if (lead_ones >= cfg.preamble_min) begin
               rx_phase = PH_BYTE;
               byte_sr = '0;
               bit_count = '0;
               byte_count = '0;
            end else begin
               lead_ones = '0;
            end
         end
         PH_BYTE: begin
            byte_sr = {byte_sr[6:0], b};
            bit_count = bit_count + 1'b1;
            if (bit_count == 4'd8) begin
               if (byte_count < PKT_CAP) begin
                  pkt_bytes[byte_count] = byte_sr;
                  byte_count = byte_count + 1'b1;
               end
               rx_phase = PH_SEP;
            end
         end
         default: begin
            if (!b) begin
               rx_phase = PH_BYTE;
               byte_sr = '0;
               bit_count = '0;
            end else begin
               if (byte_count >= MIN_PACKET) queue_packet_bytes();
               rx_phase = PH_PREAMBLE;
               lead_ones = '0;
            end
         end
      endcase
   endtask

   task automatic decode_half(input logic [DUR_W-1:0] d);
      bit is_one, is_zero, paired;
      if (d < cfg.glitch_limit) return;
      is_one = (d >= cfg.one_min && d <= cfg.one_max);
      is_zero = !is_one && (d >= cfg.zero_min && d <= cfg.zero_max);
      if (!is_one && !is_zero) begin
         half_open = 1'b0;
         return;
      end
      if (!half_open) begin
         open_is_one = is_one;
         half_open = 1'b1;
         return;
      end
      paired = (is_one == open_is_one);
      // stretched closing half of the end bit still counts as a one
      if (!paired && open_is_one && is_zero && rx_phase == PH_SEP &&
          byte_count >= MIN_PACKET)
         paired = 1'b1;
      if (paired) begin
         half_open = 1'b0;
         decode_bit(open_is_one);
      end else begin
         open_is_one = is_one;
         half_open = 1'b1;
      end
   endtask

   task automatic flag_mismatch(input string what);
      if (errors < 40) $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   function automatic logic [DUR_W-1:0] pick_in(input int lo, input int hi);
      int r;
      if (lo > hi) return DUR_W'($urandom_range(DUR_MAX, 0));
      r = $urandom_range(7, 0);
      if (r == 0) return DUR_W'(lo);
      if (r == 1) return DUR_W'(hi);
      return DUR_W'($urandom_range(hi, lo));
   endfunction

   function automatic logic [DUR_W-1:0] one_half_dur();
      int lo;
      lo = cfg.one_min > cfg.glitch_limit ? cfg.one_min : cfg.glitch_limit;
      return pick_in(lo, cfg.one_max);
   endfunction

   function automatic logic [DUR_W-1:0] zero_half_dur();
      int lo;
      lo = cfg.zero_min > cfg.glitch_limit ? cfg.zero_min : cfg.glitch_limit;
      // keep clear of the one range where the two overlap
      if (cfg.one_min <= cfg.one_max && lo >= cfg.one_min && lo <= cfg.one_max)
         lo = cfg.one_max + 1;
      return pick_in(lo, cfg.zero_max);
   endfunction

   task automatic put_half(input logic [DUR_W-1:0] d);
      if (cfg.glitch_limit != 0 && $urandom_range(99, 0) < 3)
         half_queue.push_back(DUR_W'($urandom_range(cfg.glitch_limit - 1, 0)));
      if ($urandom_range(399, 0) == 0)
         half_queue.push_back(DUR_W'($urandom_range(DUR_MAX, 0)));
      half_queue.push_back(d);
      halves_made++;
   endtask

   task automatic push_bit(input bit b);
      repeat (2) put_half(b ? one_half_dur() : zero_half_dur());
   endtask

   task automatic add_burst();
      int kind, pre, nb;
      logic [7:0] pkt [$];
      logic [7:0] x;
      kind = $urandom_range(99, 0);
      if (kind < 12) begin
         repeat ($urandom_range(10, 1)) put_half(DUR_W'($urandom_range(DUR_MAX, 0)));
         return;
      end
      pre = cfg.preamble_min + $urandom_range(4, 0);
      if (kind < 17 && cfg.preamble_min > 0) pre = cfg.preamble_min - 1;
      case ($urandom_range(9, 0))
         0: nb = $urandom_range(2, 1);
         1: nb = $urandom_range(PKT_CAP + 3, PKT_CAP + 1);
         default: nb = $urandom_range(6, 3);
      endcase
      for (int i = 0; i < nb; i++) pkt.push_back(8'($urandom_range(255, 0)));
      if (nb >= 3 && $urandom_range(5, 0) == 0) begin
         pkt[0] = IDLE_FIRST;
         pkt[1] = IDLE_SECOND;
      end
      if ($urandom_range(9, 0) < 6) begin
         x = '0;
         for (int i = 0; i < nb - 1; i++) x ^= pkt[i];
         pkt[nb - 1] = x;
      end
      repeat (pre) push_bit(1'b1);
      push_bit(1'b0);
      foreach (pkt[i]) begin
         for (int k = 7; k >= 0; k--) push_bit(pkt[i][k]);
         if (i + 1 < nb) begin
            push_bit(1'b0);
         end else if ($urandom_range(3, 0) == 0) begin
            put_half(one_half_dur());
            put_half(zero_half_dur());
         end else begin
            push_bit(1'b1);
         end
      end
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
   endtask

   task automatic apply_settings(input cfg_type s);
      csr_put(CSR_GLITCH_LIMIT, s.glitch_limit);
      csr_put(CSR_ONE_MIN, s.one_min);
      csr_put(CSR_ONE_MAX, s.one_max);
      csr_put(CSR_ZERO_MIN, s.zero_min);
      csr_put(CSR_ZERO_MAX, s.zero_max);
      csr_put(CSR_PREAMBLE_MIN, s.preamble_min);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg = s;
   endtask

   task automatic drain();
      while (half_queue.size() != 0 || req_valid || due_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      logic             next_valid;
      logic [DUR_W-1:0] next_dur;
      next_valid = req_valid;
      next_dur = req_half_duration;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_took) begin
         next_valid = 1'b0;
         if (half_queue.size() != 0 && (no_gaps || $urandom_range(99, 0) >= 20)) begin
            next_valid = 1'b1;
            next_dur = half_queue.pop_front();
         end
      end
      req_valid <= next_valid;
      req_half_duration <= next_dur;
   end

   // receiver
   always @(negedge clock)
      rsp_stall <= !reset && (hold_left != 0 || (!no_gaps && $urandom_range(99, 0) < 20));

   // one long back-pressure window once the stream is well underway
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && beats_in >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_used <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rx_byte_t want;
      req_took <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         beats_in <= beats_in + 1;
         decode_half(req_half_duration);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_bytes.size() == 0) begin
            flag_mismatch($sformatf("byte %02h arrived with nothing due", rsp_data_byte));
         end else begin
            want = due_bytes.pop_front();
            check_field("data_byte", rsp_data_byte, want.data);
            check_field("byte_index", rsp_byte_index, want.index);
            check_field("packet_length", rsp_packet_length, want.length);
            check_field("checksum_ok", rsp_checksum_ok, want.good);
            check_field("is_idle", rsp_is_idle, want.idle);
            check_field("last", rsp_last, want.last);
         end
      end
   end

   initial begin
      cfg_type          plan [NUM_PHASES];
      int               want_halves [NUM_PHASES];
      int               want_bytes [NUM_PHASES];
      int               base_halves, base_bytes;
      logic [DUR_W-1:0] probes [$];
      plan[0] = cfg;
      plan[1] = '{15'd0, 15'd0, 15'd100, 15'd101, 15'd32767, 8'd20};
      // overlapping one and zero ranges, longest preamble
      plan[2] = '{15'd200, 15'd300, 15'd500, 15'd400, 15'd900, 8'd255};
      // only the top duration passes, one range empty
      plan[3] = '{15'd32767, 15'd32767, 15'd0, 15'd0, 15'd32767, 8'd1};
      plan[4] = '{GLITCH_LIMIT_RST, ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST,
                  ZERO_MAX_RST, 8'd0};
      want_halves = '{120, 80, 20, 20, 60};
      want_bytes = '{30, 20, 3, 0, 0};
      // edges of the glitch, one and zero windows, unmatched pairs, high bits
      probes = '{15'd0, 15'd14, 15'd15, 15'd47, 15'd48, 15'd72, 15'd73, 15'd84,
                 15'd85, 15'd12000, 15'd12001, 15'd32767, 15'd48, 15'd72, 15'd85,
                 15'd12000, 15'd60, 15'd100, 15'd100, 15'd16384, 15'd21845, 15'd10922};

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) apply_settings(plan[p]);
         no_gaps = (p == 1);
         if (p == 0) begin
            foreach (probes[i]) half_queue.push_back(probes[i]);
            drain();
         end
         base_halves = halves_made;
         base_bytes = bytes_predicted;
         while (halves_made - base_halves < want_halves[p] ||
                bytes_predicted - base_bytes < want_bytes[p]) begin
            while (half_queue.size() >= 32) @(posedge clock);
            add_burst();
         end
         drain();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
